// ===== hw/rtl/shapad_pkg.sv =====
// shared types and constants of the sha-512 message padder
// no dependencies; imported by the front, queue, back and top level

package shapad_pkg;

  // pad byte value, byte positions and word indexes inside a 1024-bit block
  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [6:0] LEN_START  = 7'd112;
  localparam logic [2:0] LANE_LAST  = 3'd7;
  localparam logic [3:0] LEN_HI_IDX = 4'd14;
  localparam logic [3:0] LEN_LO_IDX = 4'd15;

  // kind field codes at the input
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // command classes handed from front to back
  typedef enum logic [1:0] {
    CMD_PACK = 2'd0,  // byte that stays in the partial word
    CMD_WORD = 2'd1,  // byte that completes a word
    CMD_END  = 2'd2   // end of message, start padding
  } cmd_e;

  typedef struct packed {
    cmd_e       op;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic pad_busy;
    logic pop;
  } back_stat_t;

endpackage

// ===== hw/rtl/sha512_message_padder.sv =====
// top level of the sha-512 message padder
// depends on shapad_pkg, shapad_front, shapad_queue and shapad_back

// The padder takes one message byte or end-of-message item per cycle unless
// in_stall_o is high and emits 64-bit big-endian words, sixteen to a
// 1024-bit block, with the word index and first/final block flags alongside.
// Every eighth byte of a word produces one output word. An end-of-message
// item starts the padding sequencer in the back end, which emits one word per
// cycle while out_stall_i is low: 0x80 and zeros up to word 13, and the
// 128-bit bit count in words 14 and 15 (a block that already holds 112 or
// more bytes is closed and a second one follows). The front classifies items
// and writes them into a small command queue (QUEUE_DEPTH entries), so input
// items keep arriving while the back is padding or its output register is
// stalled, until the queue is full; bytes that only fill the partial word
// drain from the queue without needing the output slot. No reset-time sweep
// is needed; control state clears at once, output and queue data do not.

module sha512_message_padder import shapad_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input item channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  // result item channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] padded_word_o,
  output logic [3:0]  word_index_o,
  output logic        first_blk_o,
  output logic        final_block_o,
  output logic        last_of_run_o
);

  // front to queue
  logic       push;
  cmd_t       push_cmd;
  q_stat_t    q_stat;
  // queue to back
  logic       q_valid;
  cmd_t       q_cmd;
  back_stat_t back_stat;

  shapad_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  shapad_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (back_stat.pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .stat_o  (q_stat)
  );

  shapad_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .cmd_i         (q_cmd),
    .stat_o        (back_stat),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .padded_word_o (padded_word_o),
    .word_index_o  (word_index_o),
    .first_blk_o   (first_blk_o),
    .final_block_o (final_block_o),
    .last_of_run_o (last_of_run_o)
  );

  // the padding sequencer never draws commands from the queue
  a_pad_holds_queue : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    back_stat.pad_busy |-> !back_stat.pop
  ) else $error("queue popped during padding run");

  // back only pops an item the queue really holds
  a_pop_not_empty : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    back_stat.pop |-> !q_stat.empty
  ) else $error("queue popped while empty");

  // end of a padding run is always the low length word of the final block
  a_last_is_length : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_run_o && final_block_o) |-> (word_index_o == LEN_LO_IDX)
  ) else $error("padding run ended off the length word");

endmodule

// ===== hw/rtl/shapad_front.sv =====
// front end of the padder: accepts input items and classifies them
// depends on shapad_pkg; feeds shapad_queue

module shapad_front import shapad_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  logic    kind_i,
  input  logic [7:0] data_byte_i,
  input  q_stat_t q_stat_i,
  output logic    push_o,
  output cmd_t    cmd_o
);

  // byte lane within the current word, tracks the back's position
  logic [2:0] lane_q, lane_d;

  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  always_comb begin
    cmd_o.data = data_byte_i;
    lane_d     = lane_q;
    if (kind_i == KIND_END) begin
      cmd_o.op   = CMD_END;
      cmd_o.data = 8'h00;
      if (push_o) lane_d = 3'd0;
    end else begin
      cmd_o.op = (lane_q == LANE_LAST) ? CMD_WORD : CMD_PACK;
      if (push_o) lane_d = lane_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= 3'd0;
    end else begin
      lane_q <= lane_d;
    end
  end

endmodule

// ===== hw/rtl/shapad_queue.sv =====
// short command queue between the padder front and back
// depends on shapad_pkg

module shapad_queue import shapad_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    cmd_i,
  input  logic    pop_i,
  output logic    valid_o,
  output cmd_t    cmd_o,
  output q_stat_t stat_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign stat_o.full  = (count_q == CntW'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign valid_o      = !stat_o.empty;
  assign cmd_o        = mem_q[rd_ptr_q];
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/shapad_back.sv =====
// back end of the padder: word packing, length count, padding sequencer
// and the output register; depends on shapad_pkg

module shapad_back import shapad_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  cmd_t        cmd_i,
  output back_stat_t  stat_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] padded_word_o,
  output logic [3:0]  word_index_o,
  output logic        first_blk_o,
  output logic        final_block_o,
  output logic        last_of_run_o
);

  logic [55:0] partial_q, partial_d;
  logic [6:0]  pos_q, pos_d;
  logic [63:0] len_lo_q, len_lo_d;
  logic [63:0] len_hi_q, len_hi_d;
  logic        first_q, first_d;
  logic        pad_q, pad_d;
  logic [3:0]  pidx_q, pidx_d;
  logic        pfin_q, pfin_d;
  logic        pfb_q, pfb_d;

  logic        ovalid_q, ovalid_d;
  logic [63:0] oword_q, oword_d;
  logic [3:0]  oidx_q, oidx_d;
  logic        ofb_q, ofb_d;
  logic        ofin_q, ofin_d;
  logic        olast_q, olast_d;

  logic        out_ready, take, produce;
  logic [64:0] lo_sum;
  logic [2:0]  used;
  logic [3:0]  cur_idx;
  logic [63:0] pad_word;
  logic        cur_fin, cur_fb;

  assign out_ready = !ovalid_q || !out_stall_i;
  assign lo_sum    = {1'b0, len_lo_q} + 65'd8;
  assign used      = pos_q[2:0];
  assign cur_idx   = pos_q[6:3];
  assign pad_word  = {partial_q, PAD_BYTE} << {3'd7 - used, 3'b000};

  always_comb begin
    partial_d = partial_q;
    pos_d     = pos_q;
    len_lo_d  = len_lo_q;
    len_hi_d  = len_hi_q;
    first_d   = first_q;
    pad_d     = pad_q;
    pidx_d    = pidx_q;
    pfin_d    = pfin_q;
    pfb_d     = pfb_q;
    take      = 1'b0;
    produce   = 1'b0;
    oword_d   = oword_q;
    oidx_d    = oidx_q;
    ofb_d     = ofb_q;
    ofin_d    = ofin_q;
    olast_d   = olast_q;
    cur_fin   = 1'b0;
    cur_fb    = 1'b0;

    if (pad_q) begin
      // padding run: zero words, then the two length words
      produce = 1'b1;
      if (out_ready) begin
        oidx_d  = pidx_q;
        ofb_d   = pfb_q;
        ofin_d  = pfin_q;
        olast_d = pfin_q && (pidx_q == LEN_LO_IDX);
        if (pfin_q && (pidx_q == LEN_HI_IDX)) begin
          oword_d = len_hi_q;
        end else if (pfin_q && (pidx_q == LEN_LO_IDX)) begin
          oword_d = len_lo_q;
        end else begin
          oword_d = 64'd0;
        end
        if (olast_d) begin
          pad_d    = 1'b0;
          len_lo_d = 64'd0;
          len_hi_d = 64'd0;
          first_d  = 1'b1;
        end else if (pidx_q == LEN_LO_IDX) begin
          pidx_d = 4'd0;
          pfin_d = 1'b1;
          pfb_d  = 1'b0;
        end else begin
          pidx_d = pidx_q + 4'd1;
        end
      end
    end else if (q_valid_i) begin
      unique case (cmd_i.op)
        CMD_PACK: begin
          take      = 1'b1;
          partial_d = {partial_q[47:0], cmd_i.data};
          pos_d     = pos_q + 7'd1;
          len_lo_d  = lo_sum[63:0];
          len_hi_d  = len_hi_q + {63'd0, lo_sum[64]};
        end
        CMD_WORD: begin
          produce = 1'b1;
          take    = out_ready;
          if (out_ready) begin
            oword_d   = {partial_q, cmd_i.data};
            oidx_d    = cur_idx;
            ofb_d     = first_q;
            ofin_d    = 1'b0;
            olast_d   = 1'b1;
            partial_d = 56'd0;
            pos_d     = pos_q + 7'd1;
            len_lo_d  = lo_sum[63:0];
            len_hi_d  = len_hi_q + {63'd0, lo_sum[64]};
            // block wraps: later blocks are not first
            if (pos_q == 7'h7f) first_d = 1'b0;
          end
        end
        CMD_END: begin
          produce = 1'b1;
          take    = out_ready;
          cur_fin = (pos_q < LEN_START);
          cur_fb  = first_q;
          if (out_ready) begin
            oword_d   = pad_word;
            oidx_d    = cur_idx;
            ofb_d     = cur_fb;
            ofin_d    = cur_fin;
            olast_d   = 1'b0;
            pad_d     = 1'b1;
            partial_d = 56'd0;
            pos_d     = 7'd0;
            if (!cur_fin && (cur_idx == LEN_LO_IDX)) begin
              pidx_d = 4'd0;
              pfin_d = 1'b1;
              pfb_d  = 1'b0;
            end else begin
              pidx_d = cur_idx + 4'd1;
              pfin_d = cur_fin;
              pfb_d  = cur_fb;
            end
          end
        end
        default: begin
          take = 1'b1;
        end
      endcase
    end

    if (produce && out_ready) begin
      ovalid_d = 1'b1;
    end else if (!out_stall_i) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  assign stat_o.pad_busy = pad_q;
  assign stat_o.pop      = take;

  assign out_valid_o   = ovalid_q;
  assign padded_word_o = oword_q;
  assign word_index_o  = oidx_q;
  assign first_blk_o   = ofb_q;
  assign final_block_o = ofin_q;
  assign last_of_run_o = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= 56'd0;
      pos_q     <= 7'd0;
      len_lo_q  <= 64'd0;
      len_hi_q  <= 64'd0;
      first_q   <= 1'b1;
      pad_q     <= 1'b0;
      pidx_q    <= 4'd0;
      pfin_q    <= 1'b0;
      pfb_q     <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      partial_q <= partial_d;
      pos_q     <= pos_d;
      len_lo_q  <= len_lo_d;
      len_hi_q  <= len_hi_d;
      first_q   <= first_d;
      pad_q     <= pad_d;
      pidx_q    <= pidx_d;
      pfin_q    <= pfin_d;
      pfb_q     <= pfb_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oword_q <= oword_d;
    oidx_q  <= oidx_d;
    ofb_q   <= ofb_d;
    ofin_q  <= ofin_d;
    olast_q <= olast_d;
  end

endmodule
